>>> hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants for the tagged stack ALU
// Holds the operation codes, the value tags, the error codes and the request
// and result structs.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int StackDepth = 64;
	localparam int PtrW       = $clog2(StackDepth);
	localparam int DepthW     = 7;
	localparam int NumW       = 64;

	typedef enum logic [3:0] {
		FN_PUSH = 4'd0, FN_POP = 4'd1, FN_SWAP = 4'd2, FN_ROT = 4'd3,
		FN_EQ = 4'd4, FN_LT = 4'd5, FN_GT = 4'd6, FN_AND = 4'd7,
		FN_OR = 4'd8, FN_NOT = 4'd9, FN_ADD = 4'd10, FN_SUB = 4'd11,
		FN_MUL = 4'd12, FN_DIV = 4'd13, FN_MOD = 4'd14, FN_NEG = 4'd15
	} func_t;

	typedef enum logic [1:0] {
		TAG_FALSE = 2'd0, TAG_TRUE = 2'd1, TAG_NIL = 2'd2, TAG_NUM = 2'd3
	} tag_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
		ERR_TYPE = 3'd3, ERR_DIV = 3'd4
	} err_t;

	typedef struct packed {
		logic [3:0]         func;
		logic [1:0]         push_tag;
		logic signed [63:0] push_number;
	} req_t;

	typedef struct packed {
		logic [1:0]         top_tag;
		logic signed [63:0] top_number;
		logic [6:0]         stack_depth;
		logic [2:0]         error_code;
	} rsp_t;

	// divider request and result
	typedef struct packed {
		logic          start;
		logic          is_mod;
		logic [NumW-1:0] a;
		logic [NumW-1:0] b;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [NumW-1:0] r;
	} div_rsp_t;

endpackage

>>> hw/rtl/tsa_div.sv
// ----------------------------------------------------------------------------
// tsa_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; quotient
// truncates toward zero, remainder takes the dividend's sign.
// ----------------------------------------------------------------------------
module tsa_div import tsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NumW-1:0]  quo_q, rem_q, den_q;
	logic [6:0]       cnt_q;
	logic             busy_q, neg_q, is_mod_q, done_q;
	logic [NumW:0]    trial;
	logic [NumW-1:0]  rem_sh;
	logic [NumW-1:0]  mag_a, mag_b, res;

	assign mag_a  = req.a[NumW-1] ? (~req.a + 1'b1) : req.a;
	assign mag_b  = req.b[NumW-1] ? (~req.b + 1'b1) : req.b;
	assign rem_sh = {rem_q[NumW-2:0], quo_q[NumW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
	assign res    = is_mod_q ? rem_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q   <= 1'b1;
				cnt_q    <= 7'(NumW);
				quo_q    <= mag_a;
				rem_q    <= '0;
				den_q    <= mag_b;
				is_mod_q <= req.is_mod;
				neg_q    <= req.is_mod ? req.a[NumW-1] : (req.a[NumW-1] ^ req.b[NumW-1]);
			end else if (busy_q) begin
				if (trial[NumW]) begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end else begin
					rem_q <= trial[NumW-1:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = neg_q ? (~res + 1'b1) : res;

endmodule

>>> hw/rtl/tagged_stack_alu.sv
// ----------------------------------------------------------------------------
// tagged_stack_alu: stack machine ALU on tagged values
// Runs one stack operation per request on a 64-entry stack of tagged values.
// ----------------------------------------------------------------------------
// Mul builds the low product from three 32x32 partial products; div/mod run
// on the 64-step serial divider. Stack RAM gives one read a cycle. A new
// request is taken only once the previous result is handed to the output
// register; a result held by out_stall blocks only the hand-off of the next
// result.
// Reset clears the depth and the control; stack contents are undefined.
module tagged_stack_alu import tsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_MUL, S_DIVW, S_WR1, S_WR2, S_WR3, S_DONE,
		S_OUT
	} state_t;

	state_t state_q;

	logic [1:0]      tag_mem [StackDepth];
	logic [NumW-1:0] num_mem [StackDepth];

	req_t            req_q;
	logic [DepthW-1:0] depth_q;
	logic [1:0]      t1_q, t2_q, t3_q, rtag_q;
	logic [NumW-1:0] n1_q, n2_q, n3_q, rnum_q, mul_q;
	logic [1:0]      mstep_q;
	logic [1:0]      rd_tag_q;
	logic [NumW-1:0] rd_num_q;
	err_t            err_q;
	div_req_t        dreq;
	div_rsp_t        drsp;

	logic [1:0]        otag_q;
	logic [NumW-1:0]   onum_q;
	logic [DepthW-1:0] odep_q;
	err_t              oerr_q;
	logic              ovalid_q;

	// memory port
	logic            we;
	logic [PtrW-1:0] waddr, raddr;
	logic [1:0]      wtag;
	logic [NumW-1:0] wnum;

	function automatic logic [PtrW-1:0] slot(input logic [DepthW-1:0] d, input int k);
		logic [DepthW-1:0] s;
		s = d - DepthW'(k);
		return s[PtrW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr] <= wtag;
			num_mem[waddr] <= wnum;
		end
		rd_tag_q <= tag_mem[raddr];
		rd_num_q <= num_mem[raddr];
	end

	tsa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	func_t fn;
	assign fn = func_t'(req_q.func);

	logic [DepthW-1:0] need;
	always_comb begin
		case (fn)
			FN_POP, FN_NOT, FN_NEG: need = 7'd1;
			FN_ROT:                 need = 7'd3;
			default:                need = 7'd2;
		endcase
	end

	// read address per state; the top is read once the writes have landed
	always_comb begin
		case (state_q)
			S_RD1:   raddr = slot(depth_q, 1);
			S_RD2:   raddr = slot(depth_q, 2);
			S_DONE,
			S_OUT:   raddr = slot(depth_q, 1);
			default: raddr = slot(depth_q, 3);
		endcase
	end

	// write port per state; depth is already lowered for binary ops
	always_comb begin
		we = 1'b0; waddr = slot(depth_q, 1); wtag = t1_q; wnum = n1_q;
		case (state_q)
			S_WR1: begin
				we = 1'b1;
				case (fn)
					FN_PUSH: begin waddr = depth_q[PtrW-1:0]; wtag = rtag_q; wnum = rnum_q; end
					FN_SWAP, FN_ROT: begin waddr = slot(depth_q, 1); wtag = t2_q; wnum = n2_q;
						if (fn == FN_ROT) begin wtag = t3_q; wnum = n3_q; end end
					default: begin waddr = slot(depth_q, 1); wtag = rtag_q; wnum = rnum_q; end
				endcase
			end
			S_WR2: begin
				we = 1'b1;
				waddr = slot(depth_q, 2); wtag = t1_q; wnum = n1_q;
			end
			S_WR3: begin
				we = 1'b1;
				waddr = slot(depth_q, 3); wtag = t2_q; wnum = n2_q;
			end
			default: ;
		endcase
	end

	logic a_num, b_num, a_bool, b_bool;
	logic [NumW-1:0] a, b;
	assign a = n2_q;
	assign b = n1_q;
	assign a_num  = t2_q == TAG_NUM;
	assign b_num  = t1_q == TAG_NUM;
	assign a_bool = t2_q == TAG_FALSE || t2_q == TAG_TRUE;
	assign b_bool = t1_q == TAG_FALSE || t1_q == TAG_TRUE;

	logic slt, sgt;
	assign slt = $signed(a) < $signed(b);
	assign sgt = $signed(b) < $signed(a);

	localparam logic [NumW-1:0] MinNum = {1'b1, {(NumW-1){1'b0}}};

	// low 64 bits of a*b: lo*lo, then lo*hi and hi*lo shifted up
	logic [31:0]     mop_a, mop_b;
	logic [NumW-1:0] mprod;
	always_comb begin
		case (mstep_q)
			2'd0:    begin mop_a = a[31:0];  mop_b = b[31:0];  end
			2'd1:    begin mop_a = a[31:0];  mop_b = b[63:32]; end
			default: begin mop_a = a[63:32]; mop_b = b[31:0];  end
		endcase
	end
	assign mprod = 64'(mop_a) * 64'(mop_b);

	// one-entry and binary op results
	logic [1:0]      ex_tag;
	logic [NumW-1:0] ex_num;
	err_t            ex_err;
	logic            ex_pop, ex_mul, ex_div;
	always_comb begin
		ex_tag = TAG_NUM; ex_num = '0; ex_err = ERR_NONE;
		ex_pop = 1'b0; ex_mul = 1'b0; ex_div = 1'b0;
		case (fn)
			FN_SWAP: ;
			FN_NOT: begin
				if (t1_q == TAG_NUM) ex_err = ERR_TYPE;
				else ex_tag = (t1_q == TAG_TRUE) ? TAG_FALSE : TAG_TRUE;
			end
			FN_NEG: begin
				if (!b_num) ex_err = ERR_TYPE;
				else ex_num = ~b + 1'b1;
			end
			FN_EQ: begin
				ex_tag = (t1_q == t2_q && (!a_num || a == b)) ? TAG_TRUE : TAG_FALSE;
				ex_pop = 1'b1;
			end
			FN_AND, FN_OR: begin
				if (a_bool && b_bool) begin
					ex_tag = (fn == FN_AND ? (t1_q[0] & t2_q[0]) : (t1_q[0] | t2_q[0]))
						? TAG_TRUE : TAG_FALSE;
					ex_pop = 1'b1;
				end else if (a_num && b_num) begin
					ex_num = (fn == FN_AND) ? (a & b) : (a | b);
					ex_pop = 1'b1;
				end else ex_err = ERR_TYPE;
			end
			default: begin
				if (!a_num || !b_num) begin
					ex_err = ERR_TYPE;
				end else begin
					case (fn)
						FN_LT: begin ex_tag = slt ? TAG_TRUE : TAG_FALSE; ex_pop = 1'b1; end
						FN_GT: begin ex_tag = sgt ? TAG_TRUE : TAG_FALSE; ex_pop = 1'b1; end
						FN_ADD: begin ex_num = a + b; ex_pop = 1'b1; end
						FN_SUB: begin ex_num = a - b; ex_pop = 1'b1; end
						FN_MUL: ex_mul = 1'b1;
						default: begin
							if (b == '0 || (a == MinNum && b == '1)) ex_err = ERR_DIV;
							else ex_div = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			depth_q  <= '0;
			ovalid_q <= 1'b0;
			dreq     <= '0;
		end else begin
			if (state_q == S_OUT && (!ovalid_q || !out_stall)) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						err_q   <= ERR_NONE;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					if (fn == FN_PUSH) begin
						rtag_q <= req_q.push_tag;
						rnum_q <= (req_q.push_tag == TAG_NUM) ? req_q.push_number : '0;
						if (depth_q >= 7'(StackDepth)) begin
							err_q <= ERR_OVER; state_q <= S_DONE;
						end else state_q <= S_WR1;
					end else if (depth_q < need) begin
						err_q <= ERR_UNDER; state_q <= S_DONE;
					end else if (fn == FN_POP) begin
						depth_q <= depth_q - 7'd1; state_q <= S_DONE;
					end else state_q <= S_RD2;
				end
				S_RD2: begin
					t1_q <= rd_tag_q; n1_q <= rd_num_q;
					state_q <= (need == 7'd1) ? S_EXEC : S_RD3;
				end
				S_RD3: begin
					t2_q <= rd_tag_q; n2_q <= rd_num_q;
					state_q <= (fn == FN_ROT) ? S_MUL : S_EXEC;
				end
				S_MUL: begin
					if (fn == FN_ROT) begin
						t3_q <= rd_tag_q; n3_q <= rd_num_q; state_q <= S_WR1;
					end else begin
						case (mstep_q)
							2'd0: begin mul_q <= mprod; mstep_q <= 2'd1; end
							2'd1: begin
								mul_q <= mul_q + {mprod[31:0], 32'd0}; mstep_q <= 2'd2;
							end
							default: begin
								rnum_q  <= mul_q + {mprod[31:0], 32'd0};
								depth_q <= depth_q - 7'd1;
								state_q <= S_WR1;
							end
						endcase
					end
				end
				S_EXEC: begin
					rtag_q <= ex_tag;
					rnum_q <= ex_num;
					err_q  <= ex_err;
					if (ex_pop) depth_q <= depth_q - 7'd1;
					if (ex_err != ERR_NONE) state_q <= S_DONE;
					else if (ex_mul) begin
						mstep_q <= 2'd0; state_q <= S_MUL;
					end else if (ex_div) begin
						dreq    <= '{start: 1'b1, is_mod: fn == FN_MOD, a: a, b: b};
						state_q <= S_DIVW;
					end else state_q <= S_WR1;
				end
				S_DIVW: begin
					dreq.start <= 1'b0;
					if (drsp.done) begin
						rnum_q <= drsp.r; depth_q <= depth_q - 7'd1; state_q <= S_WR1;
					end
				end
				S_WR1: begin
					if (fn == FN_PUSH) begin depth_q <= depth_q + 7'd1; state_q <= S_DONE; end
					else if (fn == FN_SWAP || fn == FN_ROT) state_q <= S_WR2;
					else state_q <= S_DONE;
				end
				S_WR2: state_q <= (fn == FN_ROT) ? S_WR3 : S_DONE;
				S_WR3: state_q <= S_DONE;
				// top entry read issued here
				S_DONE: state_q <= S_OUT;
				S_OUT: begin
					if (!ovalid_q || !out_stall) begin
						odep_q <= depth_q;
						oerr_q <= err_q;
						if (depth_q == '0) begin otag_q <= TAG_NIL; onum_q <= '0; end
						else begin
							otag_q <= rd_tag_q;
							onum_q <= (rd_tag_q == TAG_NUM) ? rd_num_q : '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = '{top_tag: otag_q, top_number: onum_q, stack_depth: odep_q,
		error_code: oerr_q};

endmodule

>>> bench/tagged_stack_alu_tb.sv
// ----------------------------------------------------------------------------
// tagged_stack_alu_tb: self-checking regression for the tagged stack ALU
// Drives random and directed stack operations through the request channel,
// predicts each result with a behavioral stack model and checks every field
// of every result in order. Requests idle and the receiver stalls at random.
// ----------------------------------------------------------------------------
import tsa_pkg::*;

class stack_scoreboard;
	tag_t           tags[StackDepth];
	logic [63:0]    nums[StackDepth];
	int             depth;
	rsp_t           pending[$];
	int             mismatches;
	int             checked;
	int             err_seen[5];

	function new();
		depth = 0;
		mismatches = 0;
		checked = 0;
		foreach (err_seen[i]) err_seen[i] = 0;
	endfunction

	// apply one request to the stack copy and queue the expected result
	function void note_request(req_t rq);
		rsp_t   rs;
		err_t   err;
		int     need;
		tag_t   ta, tb, rt, t1;
		logic [63:0] a, b, r, ma, mb, n1;
		func_t  f;
		f = func_t'(rq.func);
		err = ERR_NONE;
		need = 2;
		if (f == FN_POP || f == FN_NOT || f == FN_NEG) need = 1;
		else if (f == FN_ROT) need = 3;
		if (f == FN_PUSH) begin
			if (depth >= StackDepth) err = ERR_OVER;
			else begin
				tags[depth] = tag_t'(rq.push_tag);
				nums[depth] = (rq.push_tag == TAG_NUM) ? rq.push_number : 64'd0;
				depth++;
			end
		end else if (depth < need) begin
			err = ERR_UNDER;
		end else begin
			case (f)
				FN_POP: depth--;
				FN_SWAP: begin
					t1 = tags[depth-1]; n1 = nums[depth-1];
					tags[depth-1] = tags[depth-2]; nums[depth-1] = nums[depth-2];
					tags[depth-2] = t1; nums[depth-2] = n1;
				end
				FN_ROT: begin
					// a b c -> b c a
					t1 = tags[depth-3]; n1 = nums[depth-3];
					tags[depth-3] = tags[depth-2]; nums[depth-3] = nums[depth-2];
					tags[depth-2] = tags[depth-1]; nums[depth-2] = nums[depth-1];
					tags[depth-1] = t1; nums[depth-1] = n1;
				end
				FN_NOT: begin
					if (tags[depth-1] == TAG_NUM) err = ERR_TYPE;
					else begin
						tags[depth-1] = (tags[depth-1] == TAG_TRUE) ? TAG_FALSE : TAG_TRUE;
						nums[depth-1] = 0;
					end
				end
				FN_NEG: begin
					if (tags[depth-1] != TAG_NUM) err = ERR_TYPE;
					else nums[depth-1] = -nums[depth-1];
				end
				default: begin
					ta = tags[depth-2]; tb = tags[depth-1];
					a = nums[depth-2]; b = nums[depth-1];
					rt = TAG_NUM; r = 0;
					if (f == FN_EQ) begin
						rt = (ta == tb && (ta != TAG_NUM || a == b)) ? TAG_TRUE : TAG_FALSE;
					end else if (f == FN_AND || f == FN_OR) begin
						if (ta != TAG_NUM && ta != TAG_NIL && tb != TAG_NUM && tb != TAG_NIL)
						begin
							if (f == FN_AND)
								rt = (ta == TAG_TRUE && tb == TAG_TRUE) ? TAG_TRUE : TAG_FALSE;
							else
								rt = (ta == TAG_TRUE || tb == TAG_TRUE) ? TAG_TRUE : TAG_FALSE;
						end else if (ta == TAG_NUM && tb == TAG_NUM) begin
							r = (f == FN_AND) ? (a & b) : (a | b);
						end else err = ERR_TYPE;
					end else if (ta != TAG_NUM || tb != TAG_NUM) begin
						err = ERR_TYPE;
					end else begin
						case (f)
							FN_LT: rt = ($signed(a) < $signed(b)) ? TAG_TRUE : TAG_FALSE;
							FN_GT: rt = ($signed(b) < $signed(a)) ? TAG_TRUE : TAG_FALSE;
							FN_ADD: r = a + b;
							FN_SUB: r = a - b;
							FN_MUL: r = a * b;
							default: begin
								if (b == 0 || (a == 64'h8000_0000_0000_0000 && b == '1))
									err = ERR_DIV;
								else begin
									ma = a[63] ? -a : a;
									mb = b[63] ? -b : b;
									if (f == FN_DIV) begin
										r = ma / mb;
										if (a[63] ^ b[63]) r = -r;
									end else begin
										r = ma % mb;
										if (a[63]) r = -r;
									end
								end
							end
						endcase
					end
					if (err == ERR_NONE) begin
						if (rt != TAG_NUM) r = 0;
						tags[depth-2] = rt;
						nums[depth-2] = r;
						depth--;
					end
				end
			endcase
		end
		if (depth == 0) begin
			rs.top_tag = TAG_NIL;
			rs.top_number = 0;
		end else begin
			rs.top_tag = tags[depth-1];
			rs.top_number = (tags[depth-1] == TAG_NUM) ? nums[depth-1] : 64'd0;
		end
		rs.stack_depth = depth[6:0];
		rs.error_code = err;
		err_seen[err]++;
		pending.push_back(rs);
	endfunction

	function void check_result(rsp_t got);
		rsp_t exp_rs;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: tag=%0d num=%0d depth=%0d err=%0d",
					got.top_tag, got.top_number, got.stack_depth, got.error_code);
			return;
		end
		exp_rs = pending.pop_front();
		checked++;
		if (got !== exp_rs) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
					checked, exp_rs.top_tag, exp_rs.top_number, exp_rs.stack_depth,
					exp_rs.error_code, got.top_tag, got.top_number, got.stack_depth,
					got.error_code);
		end
	endfunction
endclass

module tagged_stack_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	stack_scoreboard sb;
	int  cycles = 0;
	int  idle_pct = 26;
	bit  hold_rx = 1'b0;
	int  hold_len = 0;

	localparam int CycleLimit = 1_500_000;

	tagged_stack_alu uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tagged_stack_alu regression: fail");
			$finish;
		end
	end

	// sample at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_data);
			if (out_valid && !out_stall) sb.check_result(out_data);
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_rx) begin
			out_stall <= 1'b1;
			hold_len++;
			if (hold_len >= 40) hold_rx = 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	function automatic logic [63:0] pick_number();
		case ($urandom_range(9))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return 0;
			4: return 1;
			5, 6: return {$urandom, $urandom};
			default: return 64'($signed($urandom_range(40)) - 20);
		endcase
	endfunction

	// valid stays up after the accept; the next send or wait_drain follows at once
	task automatic send(func_t f, tag_t t = TAG_NUM, logic [63:0] n = 0);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: f, push_tag: t, push_number: n};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic push_num(logic [63:0] n);
		send(FN_PUSH, TAG_NUM, n);
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(99);
		if (sb.depth < 3 || (sel < 30 && sb.depth < StackDepth - 2)) begin
			if ($urandom_range(3) == 0) send(FN_PUSH, tag_t'($urandom_range(3)), {$urandom, $urandom});
			else push_num(pick_number());
		end else if (sel < 34) begin
			send(func_t'($urandom_range(15)), tag_t'($urandom_range(3)), {$urandom, $urandom});
		end else begin
			send(func_t'($urandom_range(15, 1)), tag_t'($urandom_range(3)), {$urandom, $urandom});
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: underflow on empty stack, every op, edge values
		for (int f = 1; f < 16; f++) send(func_t'(f));
		send(FN_PUSH, TAG_NIL, 64'h5);
		send(FN_NOT);
		send(FN_PUSH, TAG_FALSE);
		send(FN_AND);
		send(FN_PUSH, TAG_NIL);
		send(FN_OR);
		push_num(64'h8000_0000_0000_0000);
		push_num('1);
		send(FN_DIV);
		send(FN_MOD);
		push_num(0);
		send(FN_MOD);
		send(FN_POP);
		send(FN_ROT);
		send(FN_NOT);
		push_num(64'h7fff_ffff_ffff_ffff);
		send(FN_ADD);
		send(FN_NEG);
		send(FN_EQ);
		wait_drain();

		// fill to overflow; the receiver holds off at the start of the fill
		hold_len = 0;
		hold_rx = 1'b1;
		while (sb.depth < StackDepth) push_num(pick_number());
		send(FN_PUSH, TAG_TRUE);
		wait_drain();
		repeat (70) @(negedge clk);
		while (sb.depth > 4) send(FN_POP);

		// random: a stretch with no idling, then normal idling
		idle_pct = 0;
		for (int i = 0; i < 400; i++) random_item();
		idle_pct = 26;
		for (int i = 0; i < 1600; i++) random_item();
		wait_drain();
		repeat (100) @(negedge clk);

		$display("ran %0d results; errors seen none/under/over/type/div: %0d/%0d/%0d/%0d/%0d",
			sb.checked, sb.err_seen[0], sb.err_seen[1], sb.err_seen[2], sb.err_seen[3],
			sb.err_seen[4]);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("tagged_stack_alu regression: pass");
		end else begin
			$display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
			$display("tagged_stack_alu regression: fail");
		end
		$finish;
	end
endmodule

>>> tagged_stack_alu.f
hw/rtl/tsa_pkg.sv
hw/rtl/tsa_div.sv
hw/rtl/tagged_stack_alu.sv
bench/tagged_stack_alu_tb.sv
